// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMPL(lbl, clk, rstn, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |-> (con)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define AST_NEXT(lbl, clk, rstn, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |=> (con)) \
        else $error(msg);

`endif

// ===== hdl/tlc_pkg.sv =====
// Types, constants and row functions for the two-level cache model.
package tlc_pkg;

    localparam int MAX_WAYS    = 8;
    localparam int WAY_W       = 3;
    localparam int L1_ROWS_LOG = 8;
    localparam int L2_ROWS_LOG = 12;
    localparam int L1_ROWS     = 1 << L1_ROWS_LOG;
    localparam int L2_ROWS     = 1 << L2_ROWS_LOG;

    localparam logic [2:0] CFG_BLOCK = 3'd0;
    localparam logic [2:0] CFG_L1SZ  = 3'd1;
    localparam logic [2:0] CFG_L2SZ  = 3'd2;
    localparam logic [2:0] CFG_L1WAY = 3'd3;
    localparam logic [2:0] CFG_L2WAY = 3'd4;
    localparam logic [2:0] CFG_WALLOC = 3'd5;

    typedef struct packed {
        logic [31:0]      blk;
        logic             valid;
        logic             dirty;
        logic [WAY_W-1:0] rank;
    } t_way;

    typedef t_way [MAX_WAYS-1:0] t_row;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
    } t_look;

    function automatic t_look f_lookup(t_row row, logic [3:0] ways, logic [31:0] addr,
                                       logic [4:0] sh);
        t_look r;
        r.hit = 1'b0;
        r.way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (4'(w) < ways && !r.hit && row[w].valid &&
                ((row[w].blk >> sh) == (addr >> sh))) begin
                r.hit = 1'b1;
                r.way = WAY_W'(w);
            end
        end
        return r;
    endfunction

    // Make a way most recent; ranks above its old rank drop by one.
    function automatic t_row f_touch(t_row row, logic [3:0] ways, logic [WAY_W-1:0] way);
        t_row             r;
        logic [WAY_W-1:0] old;
        r   = row;
        old = row[way].rank;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (4'(w) < ways && WAY_W'(w) != way && row[w].rank > old) begin
                r[w].rank = row[w].rank - 3'd1;
            end
        end
        r[way].rank = WAY_W'(ways - 4'd1);
        return r;
    endfunction

    // First invalid way, else lowest rank.
    function automatic logic [WAY_W-1:0] f_victim(t_row row, logic [3:0] ways);
        logic             found;
        logic [WAY_W-1:0] v;
        logic [3:0]       best;
        found = 1'b0;
        v     = '0;
        best  = 4'hF;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (4'(w) < ways && !found && !row[w].valid) begin
                found = 1'b1;
                v     = WAY_W'(w);
            end
        end
        if (!found) begin
            for (int w = 0; w < MAX_WAYS; w++) begin
                if (4'(w) < ways && {1'b0, row[w].rank} < best) begin
                    best = {1'b0, row[w].rank};
                    v    = WAY_W'(w);
                end
            end
        end
        return v;
    endfunction

    function automatic t_row f_clear_row();
        t_row r;
        for (int w = 0; w < MAX_WAYS; w++) begin
            r[w].blk   = '0;
            r[w].valid = 1'b0;
            r[w].dirty = 1'b0;
            r[w].rank  = WAY_W'(w);
        end
        return r;
    endfunction

endpackage

// ===== hdl/two_level_lru_cache_model_core.sv =====
// Two-level inclusive LRU cache model: sequencer over set-row tag memories.
// An L1 hit or no-allocate write strobes from the lookup step; a fill goes on through
// back-invalidate, L1 fill and dirty write-back steps as needed. A new item is taken
// only from idle, after the read-modify-write steps on the two tag RAMs are done.
// Reset and every known configuration write run a clearing pass over the 4096
// L2 rows (L1 cleared within it), busy high. No output stall.
module two_level_lru_cache_model_core
    import tlc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // access command
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_operation,
    input  logic [31:0] i_address,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    // result
    output logic        o_valid,
    output logic        o_l1_hit,
    output logic        o_l2_accessed,
    output logic        o_l2_hit,
    output logic        o_memory_access,
    output logic        o_l2_victim_valid,
    output logic [31:0] o_l2_victim_address,
    output logic        o_back_invalidate,
    output logic        o_l1_dirty_writeback,
    output logic        o_l1_filled
);

`include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_L_RD, S_L_EX, S_BI_RD, S_BI_EX,
        S_F_RD, S_F_EX, S_WB_RD, S_WB_EX
    } t_state;

    t_state r_state, n_state;

    // config registers
    logic [3:0] r_bsz,  n_bsz;
    logic [4:0] r_l1sz, n_l1sz;
    logic [4:0] r_l2sz, n_l2sz;
    logic [1:0] r_l1w,  n_l1w;
    logic [1:0] r_l2w,  n_l2w;
    logic       r_wa,   n_wa;

    logic [L2_ROWS_LOG-1:0] r_clr, n_clr;
    logic        r_op, n_op;
    logic [31:0] r_addr, n_addr;
    logic [31:0] r_vaddr, n_vaddr;   // back-invalidate / write-back target

    // result registers, driven straight onto the ports
    logic        r_valid, n_valid;
    logic        r_l1h, n_l1h, r_l2a, n_l2a, r_l2h, n_l2h, r_mem, n_mem;
    logic        r_vv, n_vv, r_binv, n_binv, r_wb, n_wb, r_fill, n_fill;
    logic [31:0] r_va, n_va;

    // tag memories: one row per set, all ways side by side
    t_row r_l1_mem [L1_ROWS];
    t_row r_l2_mem [L2_ROWS];
    t_row r_l1_q, r_l2_q;

    logic                   w_we1, w_we2;
    logic [L1_ROWS_LOG-1:0] w_wa1;
    logic [L2_ROWS_LOG-1:0] w_wa2;
    t_row                   w_wd1, w_wd2;

    // geometry
    logic [3:0] w_bs;
    logic [4:0] w_sz1, w_sz2, w_lb1, w_lb2;
    logic [1:0] w_wl1, w_wl2;
    logic [4:0] w_sl1, w_sl2;
    logic [3:0] w_ways1, w_ways2;
    logic [4:0] w_sh1, w_sh2;
    logic [L1_ROWS_LOG-1:0] w_mask1;
    logic [L2_ROWS_LOG-1:0] w_mask2;

    always_comb begin
        w_bs  = (r_bsz > 4'd8) ? 4'd8 : r_bsz;
        w_sz1 = (r_l1sz > 5'd20) ? 5'd20 : r_l1sz;
        w_sz2 = (r_l2sz > 5'd24) ? 5'd24 : r_l2sz;
        w_lb1 = (w_sz1 > {1'b0, w_bs}) ? w_sz1 - {1'b0, w_bs} : 5'd0;
        w_lb2 = (w_sz2 > {1'b0, w_bs}) ? w_sz2 - {1'b0, w_bs} : 5'd0;
        if (w_lb1 > 5'(L1_ROWS_LOG)) w_lb1 = 5'(L1_ROWS_LOG);
        if (w_lb2 > 5'(L2_ROWS_LOG)) w_lb2 = 5'(L2_ROWS_LOG);
        w_wl1   = ({3'd0, r_l1w} > w_lb1) ? w_lb1[1:0] : r_l1w;
        w_wl2   = ({3'd0, r_l2w} > w_lb2) ? w_lb2[1:0] : r_l2w;
        w_sl1   = w_lb1 - {3'd0, w_wl1};
        w_sl2   = w_lb2 - {3'd0, w_wl2};
        w_ways1 = 4'd1 << w_wl1;
        w_ways2 = 4'd1 << w_wl2;
        w_sh1   = {1'b0, w_bs} + w_sl1;
        w_sh2   = {1'b0, w_bs} + w_sl2;
        w_mask1 = L1_ROWS_LOG'(((L1_ROWS_LOG+1)'(1) << w_sl1) - (L1_ROWS_LOG+1)'(1));
        w_mask2 = L2_ROWS_LOG'(((L2_ROWS_LOG+1)'(1) << w_sl2) - (L2_ROWS_LOG+1)'(1));
    end

    // address each memory works on in the current step
    logic [31:0] w_a1, w_a2, w_a1s, w_a2s, w_align;
    logic [L1_ROWS_LOG-1:0] w_set1;
    logic [L2_ROWS_LOG-1:0] w_set2;

    always_comb begin
        w_a1    = (r_state == S_BI_RD || r_state == S_BI_EX) ? r_vaddr : r_addr;
        w_a2    = (r_state == S_WB_RD || r_state == S_WB_EX) ? r_vaddr : r_addr;
        w_a1s   = w_a1 >> w_bs;
        w_a2s   = w_a2 >> w_bs;
        w_set1  = w_a1s[L1_ROWS_LOG-1:0] & w_mask1;
        w_set2  = w_a2s[L2_ROWS_LOG-1:0] & w_mask2;
        w_align = r_addr & ~((32'd1 << w_bs) - 32'd1);
    end

    always_ff @(posedge i_clk) begin
        if (w_we1) begin
            r_l1_mem[w_wa1] <= w_wd1;
        end
        r_l1_q <= r_l1_mem[w_set1];
    end

    always_ff @(posedge i_clk) begin
        if (w_we2) begin
            r_l2_mem[w_wa2] <= w_wd2;
        end
        r_l2_q <= r_l2_mem[w_set2];
    end

    // per-step working values
    t_look            w_lk1, w_lk2;
    logic [WAY_W-1:0] w_v1, w_v2;

    always_comb begin
        w_lk1 = f_lookup(r_l1_q, w_ways1, w_a1, w_sh1);
        w_lk2 = f_lookup(r_l2_q, w_ways2, w_a2, w_sh2);
        w_v1  = f_victim(r_l1_q, w_ways1);
        w_v2  = f_victim(r_l2_q, w_ways2);
    end

    always_comb begin
        n_state = r_state;
        n_bsz = r_bsz; n_l1sz = r_l1sz; n_l2sz = r_l2sz;
        n_l1w = r_l1w; n_l2w = r_l2w; n_wa = r_wa;
        n_clr = r_clr; n_op = r_op; n_addr = r_addr; n_vaddr = r_vaddr;
        n_valid = 1'b0;
        n_l1h = r_l1h; n_l2a = r_l2a; n_l2h = r_l2h; n_mem = r_mem;
        n_vv = r_vv; n_va = r_va; n_binv = r_binv; n_wb = r_wb; n_fill = r_fill;
        w_we1 = 1'b0; w_wa1 = w_set1; w_wd1 = r_l1_q;
        w_we2 = 1'b0; w_wa2 = w_set2; w_wd2 = r_l2_q;

        case (r_state)
            S_CLEAR: begin
                w_we2 = 1'b1;
                w_wa2 = r_clr;
                w_wd2 = f_clear_row();
                w_we1 = (r_clr[L2_ROWS_LOG-1:L1_ROWS_LOG] == '0);
                w_wa1 = r_clr[L1_ROWS_LOG-1:0];
                w_wd1 = f_clear_row();
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_op = i_operation; n_addr = i_address;
                    n_l1h = 1'b0; n_l2a = 1'b0; n_l2h = 1'b0; n_mem = 1'b0;
                    n_vv = 1'b0; n_va = '0; n_binv = 1'b0; n_wb = 1'b0; n_fill = 1'b0;
                    n_state = S_L_RD;
                end
            end
            S_L_RD: n_state = S_L_EX;
            S_L_EX: begin
                if (w_lk1.hit) begin
                    // L1 hit: touch, dirty on write, done
                    w_we1 = 1'b1;
                    w_wd1 = f_touch(r_l1_q, w_ways1, w_lk1.way);
                    if (r_op) w_wd1[w_lk1.way].dirty = 1'b1;
                    n_l1h = 1'b1; n_valid = 1'b1; n_state = S_IDLE;
                end else begin
                    n_l2a = 1'b1;
                    if (r_op && !r_wa) begin
                        // no-allocate write miss: mark L2 only
                        if (w_lk2.hit) begin
                            w_we2 = 1'b1;
                            w_wd2 = f_touch(r_l2_q, w_ways2, w_lk2.way);
                            w_wd2[w_lk2.way].dirty = 1'b1;
                            n_l2h = 1'b1;
                        end else begin
                            n_mem = 1'b1;
                        end
                        n_valid = 1'b1; n_state = S_IDLE;
                    end else if (w_lk2.hit) begin
                        w_we2 = 1'b1;
                        w_wd2 = f_touch(r_l2_q, w_ways2, w_lk2.way);
                        n_l2h = 1'b1; n_state = S_F_RD;
                    end else begin
                        // L2 fill from memory
                        n_mem = 1'b1;
                        w_we2 = 1'b1;
                        w_wd2 = f_touch(r_l2_q, w_ways2, w_v2);
                        w_wd2[w_v2].valid = 1'b1;
                        w_wd2[w_v2].dirty = 1'b0;
                        w_wd2[w_v2].blk   = w_align;
                        if (r_l2_q[w_v2].valid) begin
                            n_vv = 1'b1; n_va = r_l2_q[w_v2].blk;
                            n_vaddr = r_l2_q[w_v2].blk;
                            n_state = S_BI_RD;
                        end else begin
                            n_state = S_F_RD;
                        end
                    end
                end
            end
            S_BI_RD: n_state = S_BI_EX;
            S_BI_EX: begin
                // keep L1 inside L2
                if (w_lk1.hit) begin
                    w_we1 = 1'b1;
                    w_wd1[w_lk1.way].valid = 1'b0;
                    n_binv = 1'b1;
                end
                n_state = S_F_RD;
            end
            S_F_RD: n_state = S_F_EX;
            S_F_EX: begin
                w_we1 = 1'b1;
                w_wd1 = f_touch(r_l1_q, w_ways1, w_v1);
                w_wd1[w_v1].valid = 1'b1;
                w_wd1[w_v1].dirty = r_op;
                w_wd1[w_v1].blk   = w_align;
                n_fill = 1'b1;
                if (r_l1_q[w_v1].valid && r_l1_q[w_v1].dirty) begin
                    n_vaddr = r_l1_q[w_v1].blk;
                    n_state = S_WB_RD;
                end else begin
                    n_valid = 1'b1; n_state = S_IDLE;
                end
            end
            S_WB_RD: n_state = S_WB_EX;
            S_WB_EX: begin
                // dirty L1 victim lands in L2 only if still present
                if (w_lk2.hit) begin
                    w_we2 = 1'b1;
                    w_wd2 = f_touch(r_l2_q, w_ways2, w_lk2.way);
                    w_wd2[w_lk2.way].dirty = 1'b1;
                    n_wb = 1'b1;
                end
                n_valid = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase

        // any known register write flushes both levels
        if (i_cfg_valid && i_cfg_index <= CFG_WALLOC) begin
            case (i_cfg_index)
                CFG_BLOCK:  n_bsz  = i_cfg_data[3:0];
                CFG_L1SZ:   n_l1sz = i_cfg_data;
                CFG_L2SZ:   n_l2sz = i_cfg_data;
                CFG_L1WAY:  n_l1w  = i_cfg_data[1:0];
                CFG_L2WAY:  n_l2w  = i_cfg_data[1:0];
                CFG_WALLOC: n_wa   = i_cfg_data[0];
                default:    n_wa   = r_wa;
            endcase
            n_clr   = '0;
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
            r_bsz   <= 4'd4;
            r_l1sz  <= 5'd12;
            r_l2sz  <= 5'd16;
            r_l1w   <= 2'd1;
            r_l2w   <= 2'd2;
            r_wa    <= 1'b1;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
            r_bsz   <= n_bsz;
            r_l1sz  <= n_l1sz;
            r_l2sz  <= n_l2sz;
            r_l1w   <= n_l1w;
            r_l2w   <= n_l2w;
            r_wa    <= n_wa;
        end
        r_op <= n_op; r_addr <= n_addr; r_vaddr <= n_vaddr;
        r_l1h <= n_l1h; r_l2a <= n_l2a; r_l2h <= n_l2h; r_mem <= n_mem;
        r_vv <= n_vv; r_va <= n_va; r_binv <= n_binv; r_wb <= n_wb; r_fill <= n_fill;
    end

    assign o_busy               = (r_state != S_IDLE);
    assign o_cfg_ready          = 1'b1;
    assign o_valid              = r_valid;
    assign o_l1_hit             = r_l1h;
    assign o_l2_accessed        = r_l2a;
    assign o_l2_hit             = r_l2h;
    assign o_memory_access      = r_mem;
    assign o_l2_victim_valid    = r_vv;
    assign o_l2_victim_address  = r_va;
    assign o_back_invalidate    = r_binv;
    assign o_l1_dirty_writeback = r_wb;
    assign o_l1_filled          = r_fill;

    `AST_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid, "result strobe longer than one cycle")
    `AST_IMPL(a_hit_no_l2, i_clk, i_rst_n, o_valid && o_l1_hit, !o_l2_accessed && !o_l1_filled, "L1 hit went on to L2")
    `AST_IMPL(a_binv_victim, i_clk, i_rst_n, o_valid && o_back_invalidate, o_l2_victim_valid && o_memory_access, "back-invalidate without L2 victim")
    `AST_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy && !i_cfg_valid, o_busy, "accepted item did not raise busy")

endmodule
